// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

    localparam int JSU_QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_STRING = 3'd1,
        PH_ESCAPE = 3'd2,
        PH_HEX1   = 3'd3,
        PH_HEX2   = 3'd4,
        PH_HEX3   = 3'd5,
        PH_HEX4   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Work for the back end: one to three results of the same kind.
    typedef struct packed {
        logic [1:0] nres;
        kind_t      kind;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } cmd_t;

endpackage

// ===== rtl/jsu_front.sv =====
// Front end: parser state machine that turns text items into result commands.
module jsu_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    text_byte,
    input  logic          text_ended,
    output logic          push,
    output jsu_pkg::cmd_t cmd
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    phase_t      phase_reg, phase_next;
    logic [15:0] cp_reg, cp_next;

    logic [4:0]  hex;
    logic [15:0] cp_new;

    // Hex digit value, bit 4 set when the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

    assign hex    = hex_value(text_byte);
    assign cp_new = {cp_reg[11:0], hex[3:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cp_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cp_reg    <= cp_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cp_next    = cp_reg;
        push       = 1'b0;
        cmd        = '{nres: 2'd1, kind: KIND_ERROR, byte0: 8'h00, byte1: 8'h00,
                       byte2: 8'h00};
        if (accept)
        begin
            if (text_ended)
            begin
                phase_next = PH_IDLE;
                cp_next    = '0;
                push       = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_STRING:
                    begin
                        if (text_byte == CH_QUOTE)
                        begin
                            phase_next = PH_IDLE;
                            push       = 1'b1;
                            cmd.kind   = KIND_DONE;
                        end
                        else if (text_byte == CH_BSL)
                        begin
                            phase_next = PH_ESCAPE;
                        end
                        else if (text_byte < CH_SPACE)
                        begin
                            phase_next = PH_IDLE;
                            cp_next    = '0;
                            push       = 1'b1;
                        end
                        else
                        begin
                            push      = 1'b1;
                            cmd.kind  = KIND_BYTE;
                            cmd.byte0 = text_byte;
                        end
                    end
                    PH_ESCAPE:
                    begin
                        push       = 1'b1;
                        cmd.kind   = KIND_BYTE;
                        phase_next = PH_STRING;
                        case (text_byte)
                            8'h22:   cmd.byte0 = 8'h22;
                            8'h5C:   cmd.byte0 = 8'h5C;
                            8'h2F:   cmd.byte0 = 8'h2F;
                            8'h62:   cmd.byte0 = 8'h08;
                            8'h66:   cmd.byte0 = 8'h0C;
                            8'h6E:   cmd.byte0 = 8'h0A;
                            8'h72:   cmd.byte0 = 8'h0D;
                            8'h74:   cmd.byte0 = 8'h09;
                            8'h75:
                            begin
                                push       = 1'b0;
                                cp_next    = '0;
                                phase_next = PH_HEX1;
                            end
                            default:
                            begin
                                cmd.kind   = KIND_ERROR;
                                phase_next = PH_IDLE;
                                cp_next    = '0;
                            end
                        endcase
                    end
                    PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4:
                    begin
                        if (hex[4])
                        begin
                            phase_next = PH_IDLE;
                            cp_next    = '0;
                            push       = 1'b1;
                        end
                        else
                        begin
                            cp_next = cp_new;
                            if (phase_reg != PH_HEX4)
                            begin
                                phase_next = phase_t'(phase_reg + 3'd1);
                            end
                            else
                            begin
                                phase_next = PH_STRING;
                                push       = 1'b1;
                                cmd.kind   = KIND_BYTE;
                                if (cp_new[15:7] == '0)
                                begin
                                    cmd.byte0 = cp_new[7:0];
                                end
                                else if (cp_new[15:11] == '0)
                                begin
                                    cmd.nres  = 2'd2;
                                    cmd.byte0 = {3'b110, cp_new[10:6]};
                                    cmd.byte1 = {2'b10, cp_new[5:0]};
                                end
                                else
                                begin
                                    cmd.nres  = 2'd3;
                                    cmd.byte0 = {4'hE, cp_new[15:12]};
                                    cmd.byte1 = {2'b10, cp_new[11:6]};
                                    cmd.byte2 = {2'b10, cp_new[5:0]};
                                end
                            end
                        end
                    end
                    default:
                    begin
                        // idle, and the unused phase code
                        if (text_byte == CH_QUOTE)
                        begin
                            phase_next = PH_STRING;
                            cp_next    = '0;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            cp_next    = '0;
                            push       = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/jsu_queue.sv =====
// Short register queue of result commands between front and back end.
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output jsu_pkg::cmd_t head
);
    import jsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: walks the head command and hands out its results one item at a time.
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  jsu_pkg::cmd_t cmd,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_byte,
    output logic [1:0]    m_kind,
    output logic          m_last
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       take;

    assign m_valid = cmd_valid;
    assign m_kind  = cmd.kind;
    assign m_last  = (idx_reg == cmd.nres - 2'd1);
    assign take    = m_valid && m_ready;
    assign pop     = take && m_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    m_byte = cmd.byte0;
            2'd1:    m_byte = cmd.byte1;
            default: m_byte = cmd.byte2;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = m_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

// ===== rtl/json_string_unescape.sv =====
// Top level of the JSON string unescaper: parser front end, command queue, result back end.
//
//  channel   | dir | tdata            | tuser            | tlast
//  s_axis    | in  | [7:0] text_byte  | [0] text_ended   | -
//  m_axis    | out | [7:0] out_byte   | [1:0] result_kind| last_of_run
//
// One text item is taken per cycle while the command queue has room; the parser
// state updates in that cycle and its command is offered once it reaches the queue head.
// Each item yields zero to three results, sent one per cycle while m_axis_tready
// is high, so a three-byte UTF-8 code point goes out as three results.
// Input stalls only while the queue holds QUEUE_DEPTH commands. Reset (rst_n low,
// asynchronous) empties the queue and returns the parser to idle.
module json_string_unescape #(
    parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tuser,   // [0] text_ended
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] result_kind
    output logic       m_axis_tlast    // last_of_run
);
    import jsu_pkg::*;

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic not_empty;
    cmd_t head;

    // Input is taken whenever the queue has a free slot.
    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    jsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .text_byte  (s_axis_tdata),
        .text_ended (s_axis_tuser),
        .push       (push),
        .cmd        (push_cmd)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (not_empty),
        .cmd       (head),
        .pop       (pop),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_byte    (m_axis_tdata),
        .m_kind    (m_axis_tuser),
        .m_last    (m_axis_tlast)
    );

endmodule

// ===== bench/json_string_unescape_test.sv =====
// Self-checking bench for the JSON string unescaper: directed, random, stall and drain tests.
`timescale 1ns / 1ps

module json_string_unescape_test;
    import jsu_pkg::*;

    localparam int          CYCLE_LIMIT = 300000; // several times the slowest legal run
    localparam int unsigned HOLD_CYCLES = 60;     // long output hold-off
    localparam int          SETTLE      = 20;     // quiet cycles after the last result

    localparam logic [7:0] QUOTE     = 8'h22;
    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] U_LETTER  = 8'h75;

    // letters allowed after a backslash, \u excluded
    localparam logic [7:0] SHORT_ESC [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62,
                                             8'h66, 8'h6E, 8'h72, 8'h74};

    // one decoded result as seen on the master side
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } text_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = 1'b0;
    logic       m_tready = 1'b0;

    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    // shadow of the parser state, updated on every accepted text item
    phase_t       parse_phase = PH_IDLE;
    logic [15:0]  code_acc = 16'h0000;
    text_result_t decoded_q [$];

    int          failures = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_seen = 0;
    int unsigned stall_left = 0;

    json_string_unescape uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),      // [7:0] text_byte
        .s_axis_tuser  (s_tuser),      // [0] text_ended
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata), // [7:0] out_byte
        .m_axis_tuser  (m_axis_tuser), // [1:0] result_kind
        .m_axis_tlast  (m_axis_tlast)  // last_of_run
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // hex digit value, bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return 5'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return 5'(c - 8'h57);
        if (c >= 8'h41 && c <= 8'h46)
            return 5'(c - 8'h37);
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10)
            return 8'h30 + v;
        return (upper ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        if (c == U_LETTER)
            return 1'b1;
        foreach (SHORT_ESC[i])
            if (c == SHORT_ESC[i])
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void count_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endfunction

    // Expected results of one accepted text item; advances the shadow state.
    task automatic predict_unescape(input logic [7:0] c, input logic ended);
        text_result_t r [3];
        logic [4:0]   d;
        logic [15:0]  v;
        logic [7:0]   b;
        bit           bad;
        bit           hit;
        int           n;
        n = 0;
        bad = 1'b0;
        if (ended)
            bad = 1'b1;
        else
        begin
            case (parse_phase)
                PH_STRING:
                    if (c == QUOTE)
                    begin
                        parse_phase = PH_IDLE;
                        r[0] = '{8'h00, KIND_DONE, 1'b0};
                        n = 1;
                    end
                    else if (c == BACKSLASH)
                        parse_phase = PH_ESCAPE;
                    else if (c < 8'h20)
                        bad = 1'b1;              // raw control byte
                    else
                    begin
                        r[0] = '{c, KIND_BYTE, 1'b0};
                        n = 1;
                    end
                PH_ESCAPE:
                    if (c == U_LETTER)
                    begin
                        code_acc = 16'h0000;
                        parse_phase = PH_HEX1;
                    end
                    else
                    begin
                        hit = 1'b1;
                        b = 8'h00;
                        case (c)
                            8'h22:   b = 8'h22;
                            8'h5C:   b = 8'h5C;
                            8'h2F:   b = 8'h2F;
                            8'h62:   b = 8'h08;
                            8'h66:   b = 8'h0C;
                            8'h6E:   b = 8'h0A;
                            8'h72:   b = 8'h0D;
                            8'h74:   b = 8'h09;
                            default: hit = 1'b0;
                        endcase
                        if (hit)
                        begin
                            parse_phase = PH_STRING;
                            r[0] = '{b, KIND_BYTE, 1'b0};
                            n = 1;
                        end
                        else
                            bad = 1'b1;
                    end
                PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4:
                begin
                    d = hex_nibble(c);
                    if (d[4])
                        bad = 1'b1;
                    else
                    begin
                        v = {code_acc[11:0], d[3:0]};
                        code_acc = v;
                        if (parse_phase != PH_HEX4)
                            parse_phase = phase_t'(parse_phase + 1);
                        else
                        begin
                            // UTF-8 of one to three bytes; surrogates go out unpaired
                            parse_phase = PH_STRING;
                            if (v < 16'h0080)
                            begin
                                r[0] = '{v[7:0], KIND_BYTE, 1'b0};
                                n = 1;
                            end
                            else if (v < 16'h0800)
                            begin
                                r[0] = '{{3'b110, v[10:6]}, KIND_BYTE, 1'b0};
                                r[1] = '{{2'b10, v[5:0]}, KIND_BYTE, 1'b0};
                                n = 2;
                            end
                            else
                            begin
                                r[0] = '{{4'b1110, v[15:12]}, KIND_BYTE, 1'b0};
                                r[1] = '{{2'b10, v[11:6]}, KIND_BYTE, 1'b0};
                                r[2] = '{{2'b10, v[5:0]}, KIND_BYTE, 1'b0};
                                n = 3;
                            end
                        end
                    end
                end
                default:
                    // idle: only an opening quote is legal
                    if (c == QUOTE)
                    begin
                        parse_phase = PH_STRING;
                        code_acc = 16'h0000;
                    end
                    else
                        bad = 1'b1;
            endcase
        end
        if (bad)
        begin
            parse_phase = PH_IDLE;
            code_acc = 16'h0000;
            r[0] = '{8'h00, KIND_ERROR, 1'b0};
            n = 1;
        end
        if (n > 0)
            r[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            decoded_q = {decoded_q, r[i]};
    endtask

    // Input and output handshakes are both looked at in one process, so the
    // expectation of an item is in place before any result it causes.
    always @(posedge clk)
    begin : result_check
        text_result_t got;
        text_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_axis_tready)
                predict_unescape(s_tdata, s_tuser);
            if (m_axis_tvalid && m_tready)
            begin
                got = '{m_axis_tdata, kind_t'(m_axis_tuser), m_axis_tlast};
                if (decoded_q.size() == 0)
                    count_failure($sformatf("unexpected result: byte %h kind %0d last %b",
                                            got.data, got.kind, got.last));
                else
                begin
                    want = decoded_q.pop_front();
                    if (got.data !== want.data || got.kind !== want.kind ||
                        got.last !== want.last)
                        count_failure($sformatf(
                            "mismatch: byte %h/%h kind %0d/%0d last %b/%b (exp/got)",
                            want.data, got.data, want.kind, got.kind, want.last, got.last));
                end
            end
        end
    end

    // Output side: random back-pressure, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_seen != hold_request)
        begin
            hold_seen = hold_request;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("json_string_unescape_test: done, errors");
            $finish;
        end
    end

    // Offer one text item, with a random gap first; returns at the edge it is taken.
    task automatic send_item(input logic [7:0] b, input logic ended);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'($urandom_range(255));
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= ended;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_unicode(input logic [15:0] v);
        send_byte(BACKSLASH);
        send_byte(U_LETTER);
        for (int i = 3; i >= 0; i--)
            send_byte(hex_char(v[i * 4 +: 4], 1'($urandom_range(1))));
    endtask

    // Hold the input quiet until every predicted result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // mostly even spread over the three UTF-8 lengths, some boundaries
    function automatic logic [15:0] random_code_point();
        logic [15:0] edges [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                   16'h0800, 16'hD800, 16'hDFFF, 16'hFFFF};
        case ($urandom_range(3))
            0:       return 16'($urandom_range(16'h007F));
            1:       return 16'($urandom_range(16'h07FF, 16'h0080));
            2:       return 16'($urandom_range(16'hFFFF, 16'h0800));
            default: return edges[$urandom_range(7)];
        endcase
    endfunction

    // A broken tail for a string; the block is idle again afterwards.
    task automatic send_fault();
        logic [7:0] b;
        logic [4:0] d;
        int         k;
        case ($urandom_range(3))
            0:  send_byte(8'($urandom_range(8'h1F)));      // raw control byte
            1:
            begin
                send_byte(BACKSLASH);
                do
                    b = 8'($urandom_range(255));
                while (is_escape_letter(b));
                send_byte(b);
            end
            2:
            begin
                send_byte(BACKSLASH);
                send_byte(U_LETTER);
                k = $urandom_range(3);
                for (int i = 0; i < k; i++)
                    send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
                do
                begin
                    b = 8'($urandom_range(255));
                    d = hex_nibble(b);
                end
                while (!d[4]);
                send_byte(b);
            end
            default:
            begin
                // truncation, possibly in the middle of an escape
                k = $urandom_range(5);
                if (k > 0)
                    send_byte(BACKSLASH);
                if (k > 1)
                    send_byte(U_LETTER);
                for (int i = 2; i < k; i++)
                    send_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
                send_item(8'($urandom_range(255)), 1'b1);
            end
        endcase
    endtask

    // One quoted string with random content; a fraction end broken.
    task automatic send_random_string();
        logic [7:0] b;
        int         n;
        int         r;
        send_byte(QUOTE);
        n = $urandom_range(6);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                do
                    b = 8'($urandom_range(8'hFF, 8'h20));
                while (b == QUOTE || b == BACKSLASH);
                send_byte(b);
            end
            else if (r < 62)
            begin
                send_byte(BACKSLASH);
                send_byte(SHORT_ESC[$urandom_range(7)]);
            end
            else if (r < 88)
                send_unicode(random_code_point());
            else
            begin
                send_fault();
                return;
            end
        end
        send_byte(QUOTE);
        // now and then some junk between strings
        if ($urandom_range(9) == 0)
        begin
            if ($urandom_range(1))
                send_item(8'($urandom_range(255)), 1'b1);
            else
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == QUOTE);
                send_byte(b);
            end
        end
    endtask

    // Boundaries of the byte classes, each escape form, each error path.
    task automatic test_directed();
        send_byte(8'h61);                  // not a quote while idle
        send_item(8'hA5, 1'b1);            // text ends while idle
        send_byte(QUOTE);
        send_byte(8'hFF);
        send_byte(8'h20);
        send_text("\\b");
        send_text("\\u07FF");              // largest two-byte code point
        send_text("\\ufFff");              // mixed-case hex, three bytes
        send_byte(QUOTE);
        send_byte(QUOTE);
        send_byte(8'h1F);                  // raw control byte
        send_text("\"\\q");                // unknown escape letter
        send_text("\"\\u0g");              // bad hex digit
        send_byte(QUOTE);
        send_item(8'h00, 1'b1);            // truncated inside a string
    endtask

    task automatic test_random_strings(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
            send_random_string();
    endtask

    // Output held off while three-byte escapes pour in: the queue fills up
    // and the input has to stall.
    task automatic test_output_stall();
        hold_request <= hold_request + 1;
        send_byte(QUOTE);
        repeat (8)
            send_unicode(16'(16'h0800 + $urandom_range(16'hF7FF)));
        send_byte(QUOTE);
        wait_drained();
    endtask

    // Input goes quiet until all results are out, mid-string and mid-escape.
    task automatic test_drain_pause();
        send_text("\"ab\\u0");
        wait_drained();
        send_text("3A9");
        wait_drained();
        send_text("\\");
        wait_drained();
        send_text("n\"");
        wait_drained();
        send_random_string();
        wait_drained();
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(17, 78);
        test_directed();
        test_random_strings(45);
        test_output_stall();

        set_idling(78, 17);
        test_random_strings(45);

        set_idling(0, 0);
        test_random_strings(45);
        test_drain_pause();

        wait_drained();
        repeat (SETTLE)
            @(posedge clk);
        if (decoded_q.size() != 0)
            count_failure($sformatf("%0d expected results never came", decoded_q.size()));

        if (failures == 0)
            $display("json_string_unescape_test: done, clean");
        else
            $display("json_string_unescape_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape.sv
bench/json_string_unescape_test.sv
